[sv/gbfs_pkg.sv]
package gbfs_pkg;

	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	localparam logic [1:0] TILE_EMPTY    = 2'd0;
	localparam logic [1:0] TILE_WALL     = 2'd1;
	localparam logic [1:0] TILE_EXPLORED = 2'd2;
	localparam logic [1:0] TILE_PATH     = 2'd3;

	// neighbor order: up, down, left, right
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam int EPOCH_W = 4;
	localparam int COUNT_W = 12;

	typedef enum logic [11:0] {
		ST_CLR   = 12'b0000_0000_0001,
		ST_IDLE  = 12'b0000_0000_0010,
		ST_RD    = 12'b0000_0000_0100,
		ST_VCLR  = 12'b0000_0000_1000,
		ST_SINIT = 12'b0000_0001_0000,
		ST_DEQ   = 12'b0000_0010_0000,
		ST_DEQW  = 12'b0000_0100_0000,
		ST_NB    = 12'b0000_1000_0000,
		ST_NBCHK = 12'b0001_0000_0000,
		ST_TR    = 12'b0010_0000_0000,
		ST_TRW   = 12'b0100_0000_0000,
		ST_SPARE = 12'b1000_0000_0000
	} state_t;

endpackage

[sv/gbfs_nbr.sv]
module gbfs_nbr #(
	parameter int CW = 6
) (
	input  logic [CW-1:0] cx,
	input  logic [CW-1:0] cy,
	input  logic [1:0]    dir,
	input  logic [CW:0]   size,
	output logic [CW-1:0] nx,
	output logic [CW-1:0] ny,
	output logic          ok
);
	import gbfs_pkg::*;

	logic [CW:0] xp1;
	logic [CW:0] yp1;

	assign xp1 = {1'b0, cx} + 1'b1;
	assign yp1 = {1'b0, cy} + 1'b1;

	always_comb begin
		nx = cx;
		ny = cy;
		ok = 1'b0;
		case (dir)
			DIR_UP: begin
				ny = cy - 1'b1;
				ok = (cy != '0);
			end
			DIR_DOWN: begin
				ny = yp1[CW-1:0];
				ok = (yp1 < size);
			end
			DIR_LEFT: begin
				nx = cx - 1'b1;
				ok = (cx != '0);
			end
			DIR_RIGHT: begin
				nx = xp1[CW-1:0];
				ok = (xp1 < size);
			end
			default: ok = 1'b0;
		endcase
	end

endmodule

[sv/grid_bfs_path_search_core.sv]
// Tile write: the result beat follows in the next cycle. Tile read: via ST_RD (registered tile RAM).
// Search: BFS from the start cell, then a trace back from the goal that marks path cells; one
// shared neighbor-step unit and one write and one read port per RAM set its pace. The 16th
// search and every 15th after it add a sweep of all visited tags (row/column rounded to a power
// of two, squared). Reset (arst_n low) clears control state; then a sweep of that size
// clears tiles and visited tags while no input beat is taken. Configuration writes are always taken.
module grid_bfs_path_search_core #(
	parameter int GRID_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,    // grid_size
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[1:0], cell_x[7:2], cell_y[13:8], tile_code[15:14], goal_x[21:16], goal_y[27:22]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_tile[1:0], found[2], path_cells[14:3]
	output logic [15:0] m_tdata
);
	import gbfs_pkg::*;

	localparam int CW    = $clog2(GRID_MAX);
	localparam int AW    = 2 * CW;
	localparam int QW    = AW + 1;
	localparam int DEPTH = 1 << AW;
	localparam int CELLS = GRID_MAX * GRID_MAX;

	logic [1:0]         tile_mem [DEPTH];
	logic [EPOCH_W-1:0] vis_mem  [DEPTH];
	logic [AW-1:0]      par_mem  [DEPTH];
	logic [AW-1:0]      que_mem  [DEPTH];

	logic               tile_we, vis_we, par_we, que_we;
	logic [AW-1:0]      tile_wa, tile_ra, vis_wa, vis_ra, par_wa, par_ra, que_wa, que_ra;
	logic [1:0]         tile_wd, tile_rd_q;
	logic [EPOCH_W-1:0] vis_wd, vis_rd_q;
	logic [AW-1:0]      par_wd, par_rd_q, que_wd, que_rd_q;

	state_t             state_q;
	logic [6:0]         grid_size_q;
	logic [CW:0]        live;
	logic [AW-1:0]      clr_q, cur_q, start_q, goal_q, nb_q;
	logic               goal_ok_q, rd_ok_q;
	logic [QW-1:0]      head_q, tail_q;
	logic [1:0]         dir_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               out_valid_q;
	logic [1:0]         out_tile_q;
	logic               out_found_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic [1:0]    in_action, in_code;
	logic [5:0]    in_x, in_y, in_gx, in_gy;
	logic          accept, in_store, goal_in_store, start_bad;
	logic [AW-1:0] in_idx, goal_idx;
	logic [CW-1:0] nx, ny;
	logic          nb_ok, nb_new, dir_last;

	assign in_action = s_tdata[1:0];
	assign in_x      = s_tdata[7:2];
	assign in_y      = s_tdata[13:8];
	assign in_code   = s_tdata[15:14];
	assign in_gx     = s_tdata[21:16];
	assign in_gy     = s_tdata[27:22];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && !out_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {1'b0, out_cnt_q, out_found_q, out_tile_q};

	assign live = (32'(grid_size_q) > GRID_MAX) ? (CW+1)'(GRID_MAX) : (CW+1)'(grid_size_q);
	assign in_store      = (32'(in_x) < GRID_MAX) && (32'(in_y) < GRID_MAX);
	assign goal_in_store = (32'(in_gx) < GRID_MAX) && (32'(in_gy) < GRID_MAX);
	assign start_bad     = (32'(in_x) >= 32'(live)) || (32'(in_y) >= 32'(live));
	assign in_idx   = {CW'(in_y), CW'(in_x)};
	assign goal_idx = {CW'(in_gy), CW'(in_gx)};
	assign dir_last = (dir_q == DIR_RIGHT);
	assign nb_new   = (tile_rd_q != TILE_WALL) && (vis_rd_q != epoch_q);

	gbfs_nbr #(.CW(CW)) u_nbr (
		.cx   (cur_q[CW-1:0]),
		.cy   (cur_q[AW-1:CW]),
		.dir  (dir_q),
		.size (live),
		.nx   (nx),
		.ny   (ny),
		.ok   (nb_ok)
	);

	// memory port steering
	always_comb begin
		tile_we = 1'b0;
		tile_wa = in_idx;
		tile_wd = in_code;
		tile_ra = in_idx;
		vis_we  = 1'b0;
		vis_wa  = nb_q;
		vis_wd  = epoch_q;
		vis_ra  = {ny, nx};
		par_we  = 1'b0;
		par_wa  = nb_q;
		par_wd  = cur_q;
		par_ra  = cur_q;
		que_we  = 1'b0;
		que_wa  = tail_q[AW-1:0];
		que_wd  = nb_q;
		que_ra  = head_q[AW-1:0];
		case (state_q)
			ST_CLR: begin
				tile_we = 1'b1;
				tile_wa = clr_q;
				tile_wd = TILE_EMPTY;
				vis_we  = 1'b1;
				vis_wa  = clr_q;
				vis_wd  = '0;
			end
			ST_VCLR: begin
				vis_we = 1'b1;
				vis_wa = clr_q;
				vis_wd = '0;
			end
			ST_IDLE: begin
				tile_we = accept && (in_action == ACT_WRITE) && in_store;
			end
			ST_SINIT: begin
				vis_we = 1'b1;
				vis_wa = start_q;
				que_we = 1'b1;
				que_wa = '0;
				que_wd = start_q;
			end
			ST_NB: begin
				tile_ra = {ny, nx};
			end
			ST_NBCHK: begin
				if (nb_new) begin
					vis_we  = 1'b1;
					par_we  = 1'b1;
					que_we  = 32'(tail_q) < CELLS;
					tile_we = 1'b1;
					tile_wa = nb_q;
					tile_wd = TILE_EXPLORED;
				end
			end
			ST_TR: begin
				if (cur_q != start_q && cur_q != goal_q) begin
					tile_we = 1'b1;
					tile_wa = cur_q;
					tile_wd = TILE_PATH;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tile_we) begin
			tile_mem[tile_wa] <= tile_wd;
		end
		tile_rd_q <= tile_mem[tile_ra];
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		vis_rd_q <= vis_mem[vis_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		par_rd_q <= par_mem[par_ra];
	end

	always_ff @(posedge clk) begin
		if (que_we) begin
			que_mem[que_wa] <= que_wd;
		end
		que_rd_q <= que_mem[que_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			grid_size_q <= 7'd63;
			clr_q       <= '0;
			epoch_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			dir_q       <= DIR_UP;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_tile_q  <= '0;
			out_found_q <= 1'b0;
			out_cnt_q   <= '0;
			rd_ok_q     <= 1'b0;
			goal_ok_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				grid_size_q <= cfg_data;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						out_tile_q  <= TILE_EMPTY;
						out_found_q <= 1'b0;
						out_cnt_q   <= '0;
						start_q     <= in_idx;
						goal_q      <= goal_idx;
						goal_ok_q   <= goal_in_store;
						rd_ok_q     <= in_store;
						if (in_action == ACT_READ) begin
							state_q <= ST_RD;
						end else if (in_action == ACT_SEARCH && !start_bad) begin
							if (&epoch_q) begin
								state_q <= ST_VCLR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= ST_SINIT;
							end
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_RD: begin
					out_tile_q  <= rd_ok_q ? tile_rd_q : TILE_EMPTY;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_VCLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						epoch_q <= EPOCH_W'(1);
						state_q <= ST_SINIT;
					end
				end
				ST_SINIT: begin
					head_q  <= '0;
					tail_q  <= QW'(1);
					state_q <= ST_DEQ;
				end
				ST_DEQ: begin
					if (head_q == tail_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= ST_DEQW;
					end
				end
				ST_DEQW: begin
					cur_q <= que_rd_q;
					dir_q <= DIR_UP;
					cnt_q <= '0;
					if (goal_ok_q && que_rd_q == goal_q) begin
						state_q <= ST_TR;
					end else begin
						state_q <= ST_NB;
					end
				end
				ST_NB: begin
					nb_q <= {ny, nx};
					if (nb_ok) begin
						state_q <= ST_NBCHK;
					end else if (dir_last) begin
						state_q <= ST_DEQ;
					end else begin
						dir_q <= dir_q + 1'b1;
					end
				end
				ST_NBCHK: begin
					if (nb_new && 32'(tail_q) < CELLS) begin
						tail_q <= tail_q + 1'b1;
					end
					if (dir_last) begin
						state_q <= ST_DEQ;
					end else begin
						dir_q   <= dir_q + 1'b1;
						state_q <= ST_NB;
					end
				end
				ST_TR: begin
					if (cur_q == start_q) begin
						out_found_q <= 1'b1;
						out_cnt_q   <= cnt_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						if (cur_q != goal_q && !(&cnt_q)) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= ST_TRW;
					end
				end
				ST_TRW: begin
					cur_q   <= par_rd_q;
					state_q <= ST_TR;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
